// File: rtl/dq_pkg.sv
// Shared types, constants and ring arithmetic for the double-ended queue.
`default_nettype none

package dq_pkg;

  localparam int DEPTH  = 16;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OP_W   = 3;
  localparam int DATA_W = 32;
  localparam int POS_W  = 4;
  localparam int STAT_W = 2;
  localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int SUM_W  = CNT_W + 1;

  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ       = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  // Controller to datapath.
  typedef struct packed {
    logic accept;      // input transfer this cycle
    logic load_now;    // result ready at accept, load output register
    logic load_fetch;  // RAM data back, finish item and load output register
  } dq_cmd_t;

  // Ring slot that lies off places after base; off stays below DEPTH.
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] base);
    logic [PTR_W-1:0] res;
    if (base == '0) begin
      res = PTR_W'(DEPTH - 1);
    end else begin
      res = base - PTR_W'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/dq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/dq_ctrl.sv
// Handshake and sequencing controller for the double-ended queue.
`default_nettype none

module dq_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  input  wire logic            need_fetch_i,
  output dq_pkg::dq_cmd_t      cmd_o
);
  import dq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_FETCH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // Output register can take a result if empty or drained this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q == S_FETCH) || !out_free;

  always_comb begin
    cmd_o            = '0;
    cmd_o.accept     = in_valid_i && !in_stall_o;
    cmd_o.load_now   = cmd_o.accept && !need_fetch_i;
    cmd_o.load_fetch = (state_q == S_FETCH);

    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.accept && need_fetch_i) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase

    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.load_now || cmd_o.load_fetch) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/dq_datapath.sv
// Ring pointers, end-value registers, element RAM and result register.
`default_nettype none

module dq_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire dq_pkg::dq_cmd_t             cmd_i,
  output logic                             need_fetch_o,
  input  wire logic [dq_pkg::OP_W-1:0]     operation_i,
  input  wire logic signed [dq_pkg::DATA_W-1:0] value_i,
  input  wire logic [dq_pkg::POS_W-1:0]    position_i,
  output logic signed [dq_pkg::DATA_W-1:0] read_value_o,
  output logic signed [dq_pkg::DATA_W-1:0] front_value_o,
  output logic signed [dq_pkg::DATA_W-1:0] back_value_o,
  output logic [dq_pkg::CNT_W-1:0]         count_o,
  output logic [dq_pkg::STAT_W-1:0]        status_o
);
  import dq_pkg::*;

  logic [PTR_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [DATA_W-1:0] front_q, front_d, back_q, back_d;
  logic [OP_W-1:0]   op_q;
  logic [STAT_W-1:0] status_q, status_d;

  logic              we;
  logic [PTR_W-1:0]  waddr, raddr;
  logic [DATA_W-1:0] rdata;
  logic              fetch;
  logic              full, empty;
  logic [CMP_W-1:0]  cnt_ext, pos_ext;

  // Result register
  logic [DATA_W-1:0] res_read_q, res_front_q, res_back_q;
  logic [CNT_W-1:0]  res_count_q;
  logic [STAT_W-1:0] res_status_q;
  logic [DATA_W-1:0] fin_read, fin_front, fin_back;
  logic [CNT_W-1:0]  fin_count;
  logic [STAT_W-1:0] fin_status;

  assign full    = (count_q == CNT_W'(DEPTH));
  assign empty   = (count_q == '0);
  assign cnt_ext = CMP_W'(count_q);
  assign pos_ext = CMP_W'(position_i);

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    front_d  = front_q;
    back_d   = back_q;
    status_d = ST_OK;
    we       = 1'b0;
    waddr    = ring_add(head_q, count_q[CNT_W-1:0]);
    raddr    = head_q;
    fetch    = 1'b0;
    case (operation_i)
      OP_PUSH_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          we      = 1'b1;
          waddr   = ring_add(head_q, count_q);
          count_d = count_q + CNT_W'(1);
          back_d  = value_i;
          if (empty) begin
            front_d = value_i;
          end
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          we      = 1'b1;
          head_d  = ring_dec(head_q);
          waddr   = head_d;
          count_d = count_q + CNT_W'(1);
          front_d = value_i;
          if (empty) begin
            back_d = value_i;
          end
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          count_d = count_q - CNT_W'(1);
          // new back comes from the RAM unless the queue empties
          raddr   = ring_add(head_q, count_q - CNT_W'(2));
          fetch   = (count_q > CNT_W'(1));
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          count_d = count_q - CNT_W'(1);
          head_d  = ring_add(head_q, CNT_W'(1));
          raddr   = head_d;
          fetch   = (count_q > CNT_W'(1));
        end
      end
      OP_READ: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status_d = ST_RANGE;
        end else begin
          raddr = ring_add(head_q, CNT_W'(cnt_ext - CMP_W'(1) - pos_ext));
          fetch = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign need_fetch_o = fetch;

  dq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.accept && we),
    .waddr_i(waddr),
    .wdata_i(value_i),
    .re_i   (cmd_i.accept && fetch),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Final values of the item, either at accept or once RAM data is back.
  always_comb begin
    if (cmd_i.load_fetch) begin
      fin_count  = count_q;
      fin_status = status_q;
      fin_read   = (op_q == OP_READ) ? rdata : '0;
      fin_front  = (op_q == OP_POP_FRONT) ? rdata : front_q;
      fin_back   = (op_q == OP_POP_BACK) ? rdata : back_q;
    end else begin
      fin_count  = count_d;
      fin_status = status_d;
      fin_read   = '0;
      fin_front  = front_d;
      fin_back   = back_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.accept) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      front_q  <= front_d;
      back_q   <= back_d;
      op_q     <= operation_i;
      status_q <= status_d;
    end else if (cmd_i.load_fetch) begin
      front_q <= fin_front;
      back_q  <= fin_back;
    end
    if (cmd_i.load_now || cmd_i.load_fetch) begin
      res_read_q   <= fin_read;
      res_front_q  <= (fin_count == '0) ? '0 : fin_front;
      res_back_q   <= (fin_count == '0) ? '0 : fin_back;
      res_count_q  <= fin_count;
      res_status_q <= fin_status;
    end
  end

  assign read_value_o  = res_read_q;
  assign front_value_o = res_front_q;
  assign back_value_o  = res_back_q;
  assign count_o       = res_count_q;
  assign status_o      = res_status_q;

endmodule

`default_nettype wire

// File: rtl/double_ended_queue.sv
// Top level of the bounded double-ended queue of signed 32-bit values.
//
// Bounded deque of DEPTH (16) signed 32-bit elements kept in a ring buffer.
// Each input transfer carries one operation: push back, push front, pop back,
// pop front, or read at an index counted from the back (index 0 is the last
// element). Each one gives exactly one output transfer with the element read,
// the front and back values after the operation (zero when empty), the count
// and a status: ok, empty (pop or read on an empty deque), full (refused
// push) or out of range (index at or past the count). Unused operation codes
// change nothing and report ok. Pushes, refused or failed operations, unused
// codes and pops that empty the deque load their result at accept; a
// successful read at index and a pop that leaves one or more elements first
// pass through the fetch state, because the new end value or the read element
// comes from the single registered read port of the element RAM. The front and
// back values live in registers, so at most one RAM read is ever needed. A
// finished result waits in the output register; the next transfer is taken in
// the same cycle that the result is drained. After reset the deque is empty and
// ready at once; the element RAM needs no clearing.
`default_nettype none

module double_ended_queue (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [dq_pkg::OP_W-1:0]          operation_i,
  input  wire logic signed [dq_pkg::DATA_W-1:0] value_i,
  input  wire logic [dq_pkg::POS_W-1:0]         position_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic signed [dq_pkg::DATA_W-1:0]      read_value_o,
  output logic signed [dq_pkg::DATA_W-1:0]      front_value_o,
  output logic signed [dq_pkg::DATA_W-1:0]      back_value_o,
  output logic [dq_pkg::CNT_W-1:0]              count_o,
  output logic [dq_pkg::STAT_W-1:0]             status_o
);
  import dq_pkg::*;

  dq_cmd_t cmd;
  logic    need_fetch;

  // Controller: handshakes and the RAM fetch step.
  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .need_fetch_i(need_fetch),
    .cmd_o       (cmd)
  );

  // Datapath: pointers, end values, element RAM and result register.
  dq_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .need_fetch_o (need_fetch),
    .operation_i  (operation_i),
    .value_i      (value_i),
    .position_i   (position_i),
    .read_value_o (read_value_o),
    .front_value_o(front_value_o),
    .back_value_o (back_value_o),
    .count_o      (count_o),
    .status_o     (status_o)
  );

endmodule

`default_nettype wire

// File: rtl/dq_checker.sv
// Port-level checker for the double-ended queue and its bind.
`default_nettype none

module dq_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_stall_o,
  input wire logic                             out_valid_o,
  input wire logic                             out_stall_i,
  input wire logic signed [dq_pkg::DATA_W-1:0] read_value_o,
  input wire logic signed [dq_pkg::DATA_W-1:0] front_value_o,
  input wire logic signed [dq_pkg::DATA_W-1:0] back_value_o,
  input wire logic [dq_pkg::CNT_W-1:0]         count_o,
  input wire logic [dq_pkg::STAT_W-1:0]        status_o
);
  import dq_pkg::*;

  // A stalled result stays up.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A refused push means the deque is at capacity.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> count_o == CNT_W'(DEPTH))
    else $error("full status with count below depth");

  // Empty status only when nothing is stored.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> count_o == '0)
    else $error("empty status with elements stored");

  // An empty deque reports zero end values and no read data.
  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (count_o == '0) |->
      (front_value_o == '0) && (back_value_o == '0) && (read_value_o == '0))
    else $error("nonzero values from empty deque");

  // A result waiting under stall blocks a new transfer.
  a_in_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("transfer taken while result is stalled");

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);

`default_nettype wire
